// ----- hdl/bsw_pkg.sv -----
// Shared types and constants for the binary square window counter.
`timescale 1ns / 1ps
`default_nettype none
package bsw_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0]  IMAGE_SIZE_RESET = 11'd6;

  // Run heights saturate at the largest window size.
  localparam int HEIGHT_W = 3;
  localparam logic [HEIGHT_W-1:0] RUN_CAP = 3'd4;

  // Result widths.
  localparam int COUNT_W = 21;
  localparam int TOTAL_W = 23;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int NUM_SIZES = 4;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One classified pixel: which window sizes end here, and whether it closes the image.
  typedef struct packed {
    logic [NUM_SIZES-1:0] hit;
    logic                 last;
  } win_item_t;

  typedef struct packed {
    logic full;
    logic almost_full;
  } queue_status_t;

endpackage
`default_nettype wire

// ----- hdl/bsw_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- hdl/bsw_front.sv -----
// Front end: pixel positions, column run heights and window classification.
`timescale 1ns / 1ps
`default_nettype none
module bsw_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_fire,
  input  wire logic                          in_pixel,
  input  wire logic [bsw_pkg::CFG_DATA_W-1:0] image_width,
  input  wire logic [bsw_pkg::CFG_DATA_W-1:0] image_height,
  output logic                               item_valid,
  output bsw_pkg::win_item_t                 item
);
  import bsw_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;
  logic [31:0]   w_ext, h_ext;
  logic          col_last, row_last;

  logic          s_valid_r;
  logic          s_pixel_r;
  logic [CW-1:0] s_col_r;
  logic          s_first_row_r;
  logic          s_col_last_r;
  logic          s_row_last_r;

  logic                byp_valid_r;
  logic [HEIGHT_W-1:0] byp_ht_r;
  logic [HEIGHT_W-1:0] rh_r [3];

  logic [HEIGHT_W-1:0] rd_height;
  logic [HEIGHT_W-1:0] above, ht, m2, m3, m4;
  logic [NUM_SIZES-1:0] hit;

  // Effective sizes, held as last position of a row and of an image.
  always_comb begin
    w_ext = 32'(image_width);
    h_ext = 32'(image_height);
    if (w_ext == 32'd0) begin
      w_last = '0;
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(w_ext - 32'd1);
    end
    if (h_ext == 32'd0) begin
      h_last = '0;
    end else if (h_ext > 32'(MAX_HEIGHT)) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(h_ext - 32'd1);
    end
    col_last = (col_r >= w_last);
    row_last = (row_r >= h_last);
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (in_fire) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  bsw_ram #(
    .WIDTH(HEIGHT_W),
    .DEPTH(MAX_WIDTH)
  ) u_heights (
    .clk    (clk),
    .wr_en  (s_valid_r),
    .wr_addr(s_col_r),
    .wr_data(ht),
    .rd_en  (in_fire),
    .rd_addr(col_r),
    .rd_data(rd_height)
  );

  // Height of this column and the windows that end at this pixel.
  always_comb begin
    if (s_first_row_r) begin
      above = '0;
    end else if (byp_valid_r) begin
      above = byp_ht_r;
    end else begin
      above = rd_height;
    end
    if (!s_pixel_r) begin
      ht = '0;
    end else if (above >= RUN_CAP) begin
      ht = RUN_CAP;
    end else begin
      ht = above + HEIGHT_W'(1);
    end
    m2 = (rh_r[0] < ht) ? rh_r[0] : ht;
    m3 = (rh_r[1] < m2) ? rh_r[1] : m2;
    m4 = (rh_r[2] < m3) ? rh_r[2] : m3;
    hit[0] = (ht != '0);
    hit[1] = hit[0] && (s_col_r >= CW'(1)) && (m2 >= HEIGHT_W'(2));
    hit[2] = hit[1] && (s_col_r >= CW'(2)) && (m3 >= HEIGHT_W'(3));
    hit[3] = hit[2] && (s_col_r >= CW'(3)) && (m4 >= HEIGHT_W'(4));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s_valid_r   <= 1'b0;
      byp_valid_r <= 1'b0;
      rh_r[0]     <= '0;
      rh_r[1]     <= '0;
      rh_r[2]     <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      s_valid_r <= in_fire;
      // A write to the column being read in the same cycle is forwarded.
      byp_valid_r <= s_valid_r && in_fire && (s_col_r == col_r);
      if (s_valid_r) begin
        if (s_col_last_r) begin
          rh_r[0] <= '0;
          rh_r[1] <= '0;
          rh_r[2] <= '0;
        end else begin
          rh_r[0] <= ht;
          rh_r[1] <= rh_r[0];
          rh_r[2] <= rh_r[1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_ht_r <= ht;
    if (in_fire) begin
      s_pixel_r     <= in_pixel;
      s_col_r       <= col_r;
      s_first_row_r <= (row_r == '0);
      s_col_last_r  <= col_last;
      s_row_last_r  <= row_last;
    end
  end

  assign item_valid = s_valid_r;
  assign item.hit   = hit;
  assign item.last  = s_col_last_r && s_row_last_r;

endmodule
`default_nettype wire

// ----- hdl/bsw_queue.sv -----
// Short queue of classified pixels between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module bsw_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  bsw_pkg::win_item_t      wr_item,
  input  wire logic               rd_en,
  output bsw_pkg::win_item_t      rd_item,
  output logic                    not_empty,
  output bsw_pkg::queue_status_t  status
);
  import bsw_pkg::*;

  win_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_wr, do_rd;

  assign do_wr = wr_en && (count_r != QCNT_W'(QUEUE_DEPTH));
  assign do_rd = rd_en && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item            = slot_r[rd_ptr_r];
  assign not_empty          = (count_r != '0);
  assign status.full        = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.almost_full = (count_r >= QCNT_W'(QUEUE_DEPTH - 1));

endmodule
`default_nettype wire

// ----- hdl/bsw_back.sv -----
// Back end: saturating window counters and the result register.
`timescale 1ns / 1ps
`default_nettype none
module bsw_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_not_empty,
  input  bsw_pkg::win_item_t             q_item,
  output logic                           q_rd_en,
  input  wire logic                      res_pop,
  output logic                           res_valid,
  output logic [bsw_pkg::COUNT_W-1:0]    res_count [bsw_pkg::NUM_SIZES],
  output logic [bsw_pkg::TOTAL_W-1:0]    res_total
);
  import bsw_pkg::*;

  logic [COUNT_W-1:0]   cnt_r [NUM_SIZES];
  logic [COUNT_W-1:0]   cnt_nxt [NUM_SIZES];
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [NUM_SIZES-1:0] bumped;
  logic [2:0]           bump_sum;
  logic                 out_valid_r;
  logic [COUNT_W-1:0]   out_cnt_r [NUM_SIZES];
  logic [TOTAL_W-1:0]   out_total_r;

  // A closing item waits while the previous result is still held.
  assign q_rd_en = q_not_empty && !(q_item.last && out_valid_r && !res_pop);

  always_comb begin
    bump_sum = '0;
    for (int k = 0; k < NUM_SIZES; k++) begin
      bumped[k]  = q_item.hit[k] && (cnt_r[k] != COUNT_MAX);
      cnt_nxt[k] = cnt_r[k] + COUNT_W'(bumped[k]);
      bump_sum   = bump_sum + 3'(bumped[k]);
    end
    total_nxt = total_r + TOTAL_W'(bump_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
      for (int k = 0; k < NUM_SIZES; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      if (res_pop) begin
        out_valid_r <= 1'b0;
      end
      if (q_rd_en) begin
        if (q_item.last) begin
          out_valid_r <= 1'b1;
          total_r     <= '0;
          for (int k = 0; k < NUM_SIZES; k++) begin
            cnt_r[k] <= '0;
          end
        end else begin
          total_r <= total_nxt;
          for (int k = 0; k < NUM_SIZES; k++) begin
            cnt_r[k] <= cnt_nxt[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en && q_item.last) begin
      out_total_r <= total_nxt;
      for (int k = 0; k < NUM_SIZES; k++) begin
        out_cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  assign res_valid = out_valid_r;
  assign res_count = out_cnt_r;
  assign res_total = out_total_r;

endmodule
`default_nettype wire

// ----- hdl/binary_square_window_counter_unit.sv -----
// Top level of the binary square window counter.
`timescale 1ns / 1ps
`default_nettype none
// The block takes a binary image one pixel per item in row-major order and
// counts the all-ones square windows of size 1, 2, 3 and 4 that lie wholly in
// the image. One result item (the four counts and their total) comes out after
// the last pixel of each image, and the counters then start again from zero.
// The image size is set through the configuration port (index 0 is the width,
// index 1 the height, both 6 after reset); a size of 0 acts as 1 and a size
// above MAX_WIDTH or MAX_HEIGHT acts as that maximum. Write the sizes only
// while no pixel is in flight; positions are kept across a write, so a new
// size may take effect in the middle of an image. The block takes one pixel
// every clock cycle while full is low: the front end keeps a column line of
// run heights in a RAM of MAX_WIDTH entries with one read and one write a
// cycle, and a write that meets a read of the same column in the same cycle is
// forwarded, so even a one-pixel-wide image runs at full rate. The last pixel
// passes the front stage register and the queue before the back end loads the
// result register. A result that is not popped is held; behind it a four-entry
// queue soaks up pixels, and full rises only once the next image end waits at
// the head of that queue and the queue is full, or holds three items while a
// pixel sits in the front stage. No clearing pass is needed after reset.
module binary_square_window_counter_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Pixel input.
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            in_pixel,
  // Result output.
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [bsw_pkg::COUNT_W-1:0]          out_count_one,
  output logic [bsw_pkg::COUNT_W-1:0]          out_count_two,
  output logic [bsw_pkg::COUNT_W-1:0]          out_count_three,
  output logic [bsw_pkg::COUNT_W-1:0]          out_count_four,
  output logic [bsw_pkg::TOTAL_W-1:0]          out_grand_total,
  // Configuration writes.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bsw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bsw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bsw_pkg::*;

  logic [CFG_DATA_W-1:0] width_r, height_r;
  logic                  in_fire;
  logic                  item_valid;
  win_item_t             front_item;
  win_item_t             q_item;
  logic                  q_not_empty;
  logic                  q_rd_en;
  queue_status_t         q_status;
  logic                  res_valid;
  logic [COUNT_W-1:0]    res_count [NUM_SIZES];
  logic [TOTAL_W-1:0]    res_total;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMAGE_SIZE_RESET;
      height_r <= IMAGE_SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end never stalls, so a pixel is refused while the queue could
  // not take both the pixel already in the front stage and a new one.
  assign full    = q_status.full || (q_status.almost_full && item_valid);
  assign in_fire = push && !full;

  bsw_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_pixel    (in_pixel),
    .image_width (width_r),
    .image_height(height_r),
    .item_valid  (item_valid),
    .item        (front_item)
  );

  bsw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (item_valid),
    .wr_item  (front_item),
    .rd_en    (q_rd_en),
    .rd_item  (q_item),
    .not_empty(q_not_empty),
    .status   (q_status)
  );

  bsw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_item     (q_item),
    .q_rd_en    (q_rd_en),
    .res_pop    (pop),
    .res_valid  (res_valid),
    .res_count  (res_count),
    .res_total  (res_total)
  );

  assign empty           = !res_valid;
  assign out_count_one   = res_count[0];
  assign out_count_two   = res_count[1];
  assign out_count_three = res_count[2];
  assign out_count_four  = res_count[3];
  assign out_grand_total = res_total;

endmodule
`default_nettype wire

// ----- hdl/bsw_checker.sv -----
// Port-level assertions for the square window counter and their bind.
`timescale 1ns / 1ps
`default_nettype none
module bsw_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            push,
  input wire logic                            full,
  input wire logic                            in_pixel,
  input wire logic                            empty,
  input wire logic                            pop,
  input wire logic [bsw_pkg::COUNT_W-1:0]     out_count_one,
  input wire logic [bsw_pkg::COUNT_W-1:0]     out_count_two,
  input wire logic [bsw_pkg::COUNT_W-1:0]     out_count_three,
  input wire logic [bsw_pkg::COUNT_W-1:0]     out_count_four,
  input wire logic [bsw_pkg::TOTAL_W-1:0]     out_grand_total,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic [bsw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input wire logic [bsw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bsw_pkg::*;

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

  // A result that is not taken stays, with its total and size-one count unchanged.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_grand_total) && $stable(out_count_one)))
    else $error("waiting result changed");

  // The total is the sum of the four counts.
  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_grand_total == (TOTAL_W'(out_count_one) + TOTAL_W'(out_count_two)
                                    + TOTAL_W'(out_count_three) + TOTAL_W'(out_count_four))))
    else $error("grand total does not match the counts");

  // Every larger window contains a smaller one ending at the same pixel.
  a_counts_nested: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_count_two <= out_count_one) && (out_count_three <= out_count_two)
                && (out_count_four <= out_count_three)))
    else $error("window counts are not nested");

endmodule

bind binary_square_window_counter_unit bsw_checker u_bsw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .in_pixel       (in_pixel),
  .empty          (empty),
  .pop            (pop),
  .out_count_one  (out_count_one),
  .out_count_two  (out_count_two),
  .out_count_three(out_count_three),
  .out_count_four (out_count_four),
  .out_grand_total(out_grand_total),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready),
  .cfg_index      (cfg_index),
  .cfg_data       (cfg_data)
);
`default_nettype wire
